/* hw/rtl/vbp_pkg.sv */
// ----------------------------------------------------------------------------
// vbp_pkg
// Shared types and constants of the varint bit packer.
// ----------------------------------------------------------------------------
package vbp_pkg;

    localparam int WORD_W = 64;                // stream word and value width
    localparam int CODE_W = 67;                // longest code: 3-bit tag + 64
    localparam int LEN_W  = 7;                 // holds code lengths 1..67
    localparam int FILL_W = 6;                 // bits held in the partial word
    localparam int SUM_W  = 8;                 // fill + length, up to 130
    localparam int BUF_W  = 3 * WORD_W;        // merge window, three words

    // op field
    localparam logic OP_ENCODE = 1'b0;
    localparam logic OP_TERM   = 1'b1;

    // width_class field
    localparam logic [1:0] CLS_8  = 2'd0;
    localparam logic [1:0] CLS_16 = 2'd1;
    localparam logic [1:0] CLS_32 = 2'd2;
    localparam logic [1:0] CLS_64 = 2'd3;

    // one code to append to the stream
    typedef struct packed {
        logic [CODE_W-1:0] bits;   // code bits, tag lowest, unused bits zero
        logic [LEN_W-1:0]  len;    // number of valid code bits
        logic              term;   // terminate: flush after appending
    } t_code;

    // words completed by one item
    typedef struct packed {
        logic [1:0]        n_words;  // 0, 1 or 2
        logic [WORD_W-1:0] w0;       // first word
        logic [WORD_W-1:0] w1;       // second word
        logic              end_mark; // words closed by a terminate item
    } t_words;

endpackage

/* hw/rtl/vbp_code_gen.sv */
// ----------------------------------------------------------------------------
// vbp_code_gen
// Picks the shortest tagged code of the width class for one item.
// ----------------------------------------------------------------------------
module vbp_code_gen
    import vbp_pkg::*;
(
    input  logic              i_op,
    input  logic [1:0]        i_cls,
    input  logic [WORD_W-1:0] i_value,
    output t_code             o_code
);

    logic [6:0] fits;    // fits[t]: value below 2^(8+8t)
    logic [2:0] tag64;

    always_comb begin
        for (int t = 0; t < 7; t++) begin
            fits[t] = (i_value >> (8 + 8 * t)) == '0;
        end
        tag64 = 3'd7;
        for (int t = 6; t >= 0; t--) begin
            if (fits[t]) begin
                tag64 = 3'(t);
            end
        end
    end

    always_comb begin
        o_code = '0;
        if (i_op == OP_TERM) begin
            o_code.bits = CODE_W'(1);
            o_code.len  = LEN_W'(1);
            o_code.term = 1'b1;
        end else begin
            case (i_cls)
                CLS_8: begin
                    if (i_value[7:3] == '0) begin
                        o_code.bits = CODE_W'({i_value[2:0], 1'b0});
                        o_code.len  = LEN_W'(4);
                    end else begin
                        o_code.bits = CODE_W'({i_value[7:0], 1'b1});
                        o_code.len  = LEN_W'(9);
                    end
                end
                CLS_16: begin
                    if (i_value[15:8] == '0) begin
                        o_code.bits = CODE_W'({i_value[7:0], 1'b0});
                        o_code.len  = LEN_W'(9);
                    end else begin
                        o_code.bits = CODE_W'({i_value[15:0], 1'b1});
                        o_code.len  = LEN_W'(17);
                    end
                end
                CLS_32: begin
                    // upper bits are zero whenever a short tag is chosen
                    if (i_value[31:8] == '0) begin
                        o_code.bits = CODE_W'({i_value[31:0], 2'd0});
                        o_code.len  = LEN_W'(10);
                    end else if (i_value[31:16] == '0) begin
                        o_code.bits = CODE_W'({i_value[31:0], 2'd1});
                        o_code.len  = LEN_W'(18);
                    end else if (i_value[31:24] == '0) begin
                        o_code.bits = CODE_W'({i_value[31:0], 2'd2});
                        o_code.len  = LEN_W'(26);
                    end else begin
                        o_code.bits = CODE_W'({i_value[31:0], 2'd3});
                        o_code.len  = LEN_W'(34);
                    end
                end
                default: begin
                    o_code.bits = {i_value, tag64};
                    o_code.len  = (tag64 == 3'd7) ? LEN_W'(CODE_W)
                                                  : LEN_W'(11 + 8 * tag64);
                end
            endcase
        end
    end

endmodule

/* hw/rtl/vbp_accum.sv */
// ----------------------------------------------------------------------------
// vbp_accum
// Holds the partial word, merges a code into it, splits off full words.
// ----------------------------------------------------------------------------
module vbp_accum
    import vbp_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_adv,
    input  t_code  i_code,
    output t_words o_words
);

    logic [WORD_W-1:0] r_partial, n_partial;
    logic [FILL_W-1:0] r_fill, n_fill;
    logic [BUF_W-1:0]  merged;
    logic [SUM_W-1:0]  total;

    always_comb begin
        merged = BUF_W'(r_partial) | (BUF_W'(i_code.bits) << r_fill);
        total  = SUM_W'(r_fill) + SUM_W'(i_code.len);

        o_words.w0       = merged[WORD_W-1:0];
        o_words.w1       = merged[2*WORD_W-1:WORD_W];
        o_words.end_mark = i_code.term;

        if (i_code.term) begin
            // a terminate item always closes exactly one word
            o_words.n_words = 2'd1;
            n_partial       = '0;
            n_fill          = '0;
        end else begin
            o_words.n_words = total[SUM_W-1:FILL_W];
            n_fill          = total[FILL_W-1:0];
            case (total[SUM_W-1:FILL_W])
                2'd0:    n_partial = merged[WORD_W-1:0];
                2'd1:    n_partial = merged[2*WORD_W-1:WORD_W];
                default: n_partial = merged[3*WORD_W-1:2*WORD_W];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_partial <= '0;
            r_fill    <= '0;
        end else if (i_adv) begin
            r_partial <= n_partial;
            r_fill    <= n_fill;
        end
    end

endmodule

/* hw/rtl/vbp_out_slot.sv */
// ----------------------------------------------------------------------------
// vbp_out_slot
// Result register for up to two words of one item, drained one per beat.
// ----------------------------------------------------------------------------
module vbp_out_slot
    import vbp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  t_words            i_words,
    output logic              o_free,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [WORD_W-1:0] o_word,
    output logic              o_end_mark,
    output logic              o_last
);

    logic [1:0]        r_cnt;
    logic [WORD_W-1:0] r_w0;
    logic [WORD_W-1:0] r_w1;
    logic              r_end;
    logic              pop;

    assign o_valid    = r_cnt != 2'd0;
    assign o_word     = r_w0;
    assign o_end_mark = r_end;
    assign o_last     = r_cnt == 2'd1;
    assign pop        = o_valid && i_ready;
    assign o_free     = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (i_load) begin
            r_cnt <= i_words.n_words;
        end else if (pop) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_w0  <= i_words.w0;
            r_w1  <= i_words.w1;
            r_end <= i_words.end_mark;
        end else if (pop) begin
            r_w0 <= r_w1;
        end
    end

endmodule

/* hw/rtl/varint_bit_packer_unit.sv */
// ----------------------------------------------------------------------------
// varint_bit_packer_unit
// Tagged length-prefix varint encoder packing codes into 64-bit words.
// ----------------------------------------------------------------------------
//
//  channel   dir  tdata               tuser                    tlast
//  s_axis    in   value[63:0]         [0] op, [2:1] width_cls  -
//  m_axis    out  packed_word[63:0]   [0] end_marked           last word of item
//
//  An accepted beat is held in the input register, where it is encoded and
//  merged into the partial word, and its words land in the result register,
//  from which the first word shows on m_axis. One item per cycle while each
//  item closes at most one word and m_axis is ready; an item that closes two
//  words holds the input while the slot drains.
//  Reset empties both registers and clears the partial word and fill count.
//  A stalled m_axis holds the result slot; items that close no word still
//  advance behind it.
// ----------------------------------------------------------------------------
module varint_bit_packer_unit
    import vbp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // input beats
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  logic [WORD_W-1:0] i_s_axis_tdata,   // [63:0] value
    input  logic [2:0]        i_s_axis_tuser,   // [0] op, [2:1] width_class
    // output beats
    output logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    output logic [WORD_W-1:0] o_m_axis_tdata,   // [63:0] packed_word
    output logic [0:0]        o_m_axis_tuser,   // [0] end_marked
    output logic              o_m_axis_tlast
);

    // input register
    logic              r_in_valid;
    logic              r_op;
    logic [1:0]        r_cls;
    logic [WORD_W-1:0] r_value;

    t_code  code;
    t_words words;
    logic   slot_free;
    logic   adv;
    logic   take;
    logic   end_mark;

    // Advance the held item when its words fit the slot; an item closing
    // no word never waits on the output side.
    assign adv  = r_in_valid && ((words.n_words == 2'd0) || slot_free);
    assign take = i_s_axis_tvalid && o_s_axis_tready;
    assign o_s_axis_tready = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (take) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_op    <= i_s_axis_tuser[0];
            r_cls   <= i_s_axis_tuser[2:1];
            r_value <= i_s_axis_tdata;
        end
    end

    // choose the code for the held item
    vbp_code_gen u_code_gen (
        .i_op    (r_op),
        .i_cls   (r_cls),
        .i_value (r_value),
        .o_code  (code)
    );

    // merge into the partial word, split off completed words
    vbp_accum u_accum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_code  (code),
        .o_words (words)
    );

    // hold the completed words and drain them one beat at a time
    vbp_out_slot u_out_slot (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (adv && (words.n_words != 2'd0)),
        .i_words    (words),
        .o_free     (slot_free),
        .o_valid    (o_m_axis_tvalid),
        .i_ready    (i_m_axis_tready),
        .o_word     (o_m_axis_tdata),
        .o_end_mark (end_mark),
        .o_last     (o_m_axis_tlast)
    );

    assign o_m_axis_tuser = end_mark;

endmodule
